// ----- rtl/core/sbc_pkg.sv -----
package sbc_pkg;

   localparam int FB_DEPTH_DEF   = 65536;
   localparam int MAX_SIDE_DEF   = 256;
   localparam int QUEUE_DEPTH    = 4;

   localparam int PIXEL_W        = 32;
   localparam int WORD_ADDR_W    = 16;
   localparam int FUNC_W         = 2;
   localparam int POS_W          = 10;
   localparam int SIDE_REG_W     = 9;
   localparam int COLOR_W        = 24;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 24;
   localparam int OP_ADDR_W      = 2 * SIDE_REG_W;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PIXEL = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPRITE_LEFT     = 3'd0,
      CSR_SPRITE_BASE_ROW = 3'd1,
      CSR_SPRITE_WIDTH    = 3'd2,
      CSR_SPRITE_HEIGHT   = 3'd3,
      CSR_SCREEN_COLUMNS  = 3'd4,
      CSR_SCREEN_ROWS     = 3'd5,
      CSR_IGNORE_COLOR    = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_NOP   = 2'd0,
      OP_PIXEL = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_kind_type;

   typedef struct packed {
      logic signed [POS_W-1:0] sprite_left;
      logic signed [POS_W-1:0] sprite_base_row;
      logic [SIDE_REG_W-1:0]   sprite_width;
      logic [SIDE_REG_W-1:0]   sprite_height;
      logic [SIDE_REG_W-1:0]   screen_columns;
      logic [SIDE_REG_W-1:0]   screen_rows;
      logic [COLOR_W-1:0]      ignore_color;
   } cfg_type;

   typedef struct packed {
      op_kind_type          kind;
      logic                 act;
      logic [OP_ADDR_W-1:0] addr;
      logic [PIXEL_W-1:0]   data;
      logic                 last;
   } op_type;

endpackage

// ----- rtl/core/sbc_channels.sv -----
interface sbc_req_if;
   import sbc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [FUNC_W-1:0]      func;
   logic [PIXEL_W-1:0]     pixel;
   logic [WORD_ADDR_W-1:0] word_address;
   logic                   last;

   modport source (output valid, output func, output pixel, output word_address,
                   output last, input ready);
   modport sink   (input valid, input func, input pixel, input word_address,
                   input last, output ready);
endinterface

interface sbc_rsp_if;
   import sbc_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] read_data;
   logic               done_res;
   logic               collided;

   modport source (output valid, output read_data, output done_res, output collided,
                   input ready);
   modport sink   (input valid, input read_data, input done_res, input collided,
                   output ready);
endinterface

// ----- rtl/core/sbc_front.sv -----
module sbc_front #(
   parameter int FB_DEPTH        = sbc_pkg::FB_DEPTH_DEF,
   parameter int MAX_SPRITE_SIDE = sbc_pkg::MAX_SIDE_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            enable,
   input  sbc_pkg::cfg_type cfg,
   sbc_req_if.sink         req_ch,
   output logic            push_valid,
   input  logic            push_ready,
   output sbc_pkg::op_type push_op
);
   import sbc_pkg::*;

   localparam int OFF_W  = $clog2(MAX_SPRITE_SIDE);
   localparam int SIDE_W = $clog2(MAX_SPRITE_SIDE + 1);

   logic [OFF_W-1:0]     col_off_ff, col_off_in;
   logic [OFF_W-1:0]     row_off_ff, row_off_in;
   logic [SIDE_W-1:0]    w_side, h_side;
   logic                 accept;
   func_type             func;
   int                   col_i, row_i;
   logic                 on_screen;
   logic [OP_ADDR_W-1:0] pix_addr;
   logic                 pix_in_range;
   logic                 word_in_range;

   always_comb begin
      if (cfg.sprite_width == '0) begin
         w_side = SIDE_W'(1);
      end else if (int'(cfg.sprite_width) > MAX_SPRITE_SIDE) begin
         w_side = SIDE_W'(MAX_SPRITE_SIDE);
      end else begin
         w_side = SIDE_W'(cfg.sprite_width);
      end
      if (cfg.sprite_height == '0) begin
         h_side = SIDE_W'(1);
      end else if (int'(cfg.sprite_height) > MAX_SPRITE_SIDE) begin
         h_side = SIDE_W'(MAX_SPRITE_SIDE);
      end else begin
         h_side = SIDE_W'(cfg.sprite_height);
      end
   end

   assign func          = func_type'(req_ch.func);
   assign req_ch.ready  = enable && push_ready;
   assign accept        = req_ch.valid && req_ch.ready;
   assign push_valid    = req_ch.valid && enable;

   assign col_i = int'($signed(cfg.sprite_left)) + int'(col_off_ff);
   assign row_i = int'($signed(cfg.sprite_base_row)) + int'(h_side) - int'(row_off_ff);

   assign on_screen = (col_i >= 0) && (row_i >= 0)
                   && (col_i < int'(cfg.screen_columns))
                   && (row_i < int'(cfg.screen_rows));

   assign pix_addr = OP_ADDR_W'(row_i[SIDE_REG_W-1:0]) * OP_ADDR_W'(cfg.screen_columns)
                   + OP_ADDR_W'(col_i[SIDE_REG_W-1:0]);

   assign pix_in_range  = 32'(pix_addr) < 32'(FB_DEPTH);
   assign word_in_range = 32'(req_ch.word_address) < 32'(FB_DEPTH);

   always_comb begin
      push_op.data = req_ch.pixel;
      push_op.last = 1'b0;
      push_op.addr = OP_ADDR_W'(req_ch.word_address);
      unique case (func)
         FUNC_PIXEL: begin
            push_op.kind = OP_PIXEL;
            push_op.act  = on_screen && pix_in_range && (req_ch.pixel != '0);
            push_op.addr = pix_addr;
            push_op.last = req_ch.last;
         end
         FUNC_WRITE: begin
            push_op.kind = OP_WRITE;
            push_op.act  = word_in_range;
         end
         FUNC_READ: begin
            push_op.kind = OP_READ;
            push_op.act  = word_in_range;
         end
         default: begin
            push_op.kind = OP_NOP;
            push_op.act  = 1'b0;
         end
      endcase
   end

   always_comb begin
      col_off_in = col_off_ff;
      row_off_in = row_off_ff;
      if (accept && func == FUNC_PIXEL) begin
         if (req_ch.last) begin
            col_off_in = '0;
            row_off_in = '0;
         end else if (int'(col_off_ff) + 1 >= int'(w_side)) begin
            col_off_in = '0;
            if (int'(row_off_ff) + 1 >= int'(h_side)) begin
               row_off_in = '0;
            end else begin
               row_off_in = row_off_ff + OFF_W'(1);
            end
         end else begin
            col_off_in = col_off_ff + OFF_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_off_ff <= '0;
         row_off_ff <= '0;
      end else begin
         col_off_ff <= col_off_in;
         row_off_ff <= row_off_in;
      end
   end

endmodule

// ----- rtl/core/sbc_queue.sv -----
module sbc_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  sbc_pkg::op_type push_op,
   output logic            pop_valid,
   input  logic            pop_ready,
   output sbc_pkg::op_type pop_op
);
   import sbc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   op_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_op     = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/core/sbc_back.sv -----
module sbc_back #(
   parameter int FB_DEPTH = sbc_pkg::FB_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sbc_pkg::COLOR_W-1:0]   ignore_color,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  sbc_pkg::op_type               pop_op,
   output logic                          clear_busy,
   sbc_rsp_if.source                     rsp_ch
);
   import sbc_pkg::*;

   localparam int AW = $clog2(FB_DEPTH);

   logic [PIXEL_W-1:0] mem [FB_DEPTH];

   logic               clr_busy_ff, clr_busy_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;
   logic               b_valid_ff, b_valid_in;
   op_type             b_op_ff;
   logic [PIXEL_W-1:0] rd_q_ff;
   logic               fwd_hit_ff;
   logic [PIXEL_W-1:0] fwd_data_ff;
   logic               hit_ff, hit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] read_data_ff;
   logic               done_ff;
   logic               collided_ff;

   logic               a_fire, b_fire;
   logic               rd_en, wr_en;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [PIXEL_W-1:0] bg;
   logic               hit_upd;
   logic               is_pixel;

   assign clear_busy = clr_busy_ff;

   assign b_fire    = b_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign pop_ready = !clr_busy_ff && (!b_valid_ff || b_fire);
   assign a_fire    = pop_valid && pop_ready;

   assign rd_addr = AW'(pop_op.addr);
   assign rd_en   = a_fire && pop_op.act;
   assign wr_addr = AW'(b_op_ff.addr);
   assign wr_en   = b_fire && b_op_ff.act
                 && (b_op_ff.kind == OP_PIXEL || b_op_ff.kind == OP_WRITE);

   assign bg       = fwd_hit_ff ? fwd_data_ff : rd_q_ff;
   assign is_pixel = b_op_ff.kind == OP_PIXEL;

   always_comb begin
      hit_upd = hit_ff;
      if (is_pixel && b_op_ff.act) begin
         if (bg != '0) begin
            hit_upd = 1'b1;
         end
         if (bg[COLOR_W-1:0] == ignore_color) begin
            hit_upd = 1'b0;
         end
      end
   end

   always_comb begin
      hit_in = hit_ff;
      if (b_fire && is_pixel) begin
         hit_in = b_op_ff.last ? 1'b0 : hit_upd;
      end
   end

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(FB_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   assign b_valid_in   = a_fire ? 1'b1 : (b_fire ? 1'b0 : b_valid_ff);
   assign rsp_valid_in = b_fire ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= b_op_ff.data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (a_fire) begin
         b_op_ff     <= pop_op;
         fwd_data_ff <= b_op_ff.data;
      end
      if (b_fire) begin
         read_data_ff <= (b_op_ff.kind == OP_READ && b_op_ff.act) ? bg : '0;
         done_ff      <= is_pixel && b_op_ff.last;
         collided_ff  <= is_pixel && b_op_ff.last && hit_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         b_valid_ff   <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         b_valid_ff   <= b_valid_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (a_fire) begin
            fwd_hit_ff <= wr_en && (wr_addr == rd_addr);
         end
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.read_data = read_data_ff;
   assign rsp_ch.done_res  = done_ff;
   assign rsp_ch.collided  = collided_ff;

endmodule

// ----- rtl/core/sprite_blit_with_collision.sv -----
// Sprite blitter with zero-pixel transparency and collision detection over a
// framebuffer of FB_DEPTH 32-bit words; a background in the ignore color clears
// the collision flag. Every request transaction yields exactly one response
// transaction; one transaction per cycle is sustained on both sides when the
// response side keeps ready high and no clearing pass runs. A request is
// classified into a 4-entry queue at acceptance, reads the framebuffer on leaving
// it and reaches the response register through a read-modify-write with forwarding
// of the previous write. After reset a clearing pass zeroes the framebuffer, one
// word per cycle; req_ch.ready stays low meanwhile, while csr writes are taken as
// usual. Write the csr registers only while no transaction is outstanding.
module sprite_blit_with_collision #(
   parameter int FB_DEPTH        = sbc_pkg::FB_DEPTH_DEF,
   parameter int MAX_SPRITE_SIDE = sbc_pkg::MAX_SIDE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   sbc_req_if.sink                         req_ch,
   sbc_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [sbc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sbc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sbc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    clear_busy;
   logic    push_valid, push_ready;
   op_type  push_op;
   logic    pop_valid, pop_ready;
   op_type  pop_op;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SPRITE_LEFT:     cfg_in.sprite_left     = csr_wdata[POS_W-1:0];
            CSR_SPRITE_BASE_ROW: cfg_in.sprite_base_row = csr_wdata[POS_W-1:0];
            CSR_SPRITE_WIDTH:    cfg_in.sprite_width    = csr_wdata[SIDE_REG_W-1:0];
            CSR_SPRITE_HEIGHT:   cfg_in.sprite_height   = csr_wdata[SIDE_REG_W-1:0];
            CSR_SCREEN_COLUMNS:  cfg_in.screen_columns  = csr_wdata[SIDE_REG_W-1:0];
            CSR_SCREEN_ROWS:     cfg_in.screen_rows     = csr_wdata[SIDE_REG_W-1:0];
            CSR_IGNORE_COLOR:    cfg_in.ignore_color    = csr_wdata[COLOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sprite_left     <= '0;
         cfg_ff.sprite_base_row <= '0;
         cfg_ff.sprite_width    <= SIDE_REG_W'(1);
         cfg_ff.sprite_height   <= SIDE_REG_W'(1);
         cfg_ff.screen_columns  <= SIDE_REG_W'(256);
         cfg_ff.screen_rows     <= SIDE_REG_W'(256);
         cfg_ff.ignore_color    <= COLOR_W'(24'hA59999);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sbc_front #(
      .FB_DEPTH        (FB_DEPTH),
      .MAX_SPRITE_SIDE (MAX_SPRITE_SIDE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (!clear_busy),
      .cfg        (cfg_ff),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op)
   );

   sbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   sbc_back #(
      .FB_DEPTH (FB_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .ignore_color (cfg_ff.ignore_color),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_op       (pop_op),
      .clear_busy   (clear_busy),
      .rsp_ch       (rsp_ch)
   );

endmodule

// ----- verif/sbc_checker.sv -----
`timescale 1ns / 1ps

module sbc_checker (
   input  logic                            clock,
   input  logic                            reset,
   sbc_req_if                              req_ch,
   sbc_rsp_if                              rsp_ch,
   input  logic                            csr_we,
   input  logic [sbc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sbc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              error_count,
   output int                              pending
);
   import sbc_pkg::*;

   typedef struct packed {
      logic [PIXEL_W-1:0] read_data;
      logic               done_res;
      logic               collided;
   } blit_result_type;

   logic [PIXEL_W-1:0] frame_copy [0:FB_DEPTH_DEF-1];
   blit_result_type    blit_results_q [$];

   int                 col_pos;
   int                 row_pos;
   logic               hit;

   int                 left_edge;
   int                 base_row;
   int                 width_reg;
   int                 height_reg;
   int                 cols_reg;
   int                 rows_reg;
   logic [COLOR_W-1:0] ignore_key;

   function automatic int side_limit(input int v);
      if (v < 1) return 1;
      if (v > MAX_SIDE_DEF) return MAX_SIDE_DEF;
      return v;
   endfunction

   function automatic void plot_pixel(input logic [PIXEL_W-1:0] pix);
      int                 col;
      int                 row;
      int                 addr;
      logic [PIXEL_W-1:0] bg;
      col = left_edge + col_pos;
      row = base_row + side_limit(height_reg) - row_pos;
      if (col < 0 || row < 0) return;
      if (col >= cols_reg || row >= rows_reg) return;
      addr = row * cols_reg + col;
      if (addr >= FB_DEPTH_DEF) return;
      if (pix == '0) return;
      bg = frame_copy[addr];
      if (bg != '0) hit = 1'b1;
      if (bg[COLOR_W-1:0] == ignore_key) hit = 1'b0;
      frame_copy[addr] = pix;
   endfunction

   function automatic void step_position();
      if (col_pos + 1 >= side_limit(width_reg)) begin
         col_pos = 0;
         if (row_pos + 1 >= side_limit(height_reg)) begin
            row_pos = 0;
         end else begin
            row_pos++;
         end
      end else begin
         col_pos++;
      end
   endfunction

   function automatic blit_result_type blit_step(input func_type f,
                                                 input logic [PIXEL_W-1:0] pix,
                                                 input logic [WORD_ADDR_W-1:0] addr,
                                                 input logic lst);
      blit_result_type res;
      res = '0;
      case (f)
         FUNC_PIXEL: begin
            plot_pixel(pix);
            step_position();
            if (lst) begin
               res.done_res = 1'b1;
               res.collided = hit;
               hit = 1'b0;
               col_pos = 0;
               row_pos = 0;
            end
         end
         FUNC_WRITE: begin
            frame_copy[addr] = pix;
         end
         FUNC_READ: begin
            res.read_data = frame_copy[addr];
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      blit_result_type want;
      if (reset) begin
         for (int i = 0; i < FB_DEPTH_DEF; i++) frame_copy[i] = '0;
         blit_results_q.delete();
         col_pos = 0;
         row_pos = 0;
         hit = 1'b0;
         left_edge = 0;
         base_row = 0;
         width_reg = 1;
         height_reg = 1;
         cols_reg = 256;
         rows_reg = 256;
         ignore_key = 24'hA59999;
         error_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_SPRITE_LEFT:     left_edge = int'($signed(csr_wdata[POS_W-1:0]));
               CSR_SPRITE_BASE_ROW: base_row = int'($signed(csr_wdata[POS_W-1:0]));
               CSR_SPRITE_WIDTH:    width_reg = int'(csr_wdata[SIDE_REG_W-1:0]);
               CSR_SPRITE_HEIGHT:   height_reg = int'(csr_wdata[SIDE_REG_W-1:0]);
               CSR_SCREEN_COLUMNS:  cols_reg = int'(csr_wdata[SIDE_REG_W-1:0]);
               CSR_SCREEN_ROWS:     rows_reg = int'(csr_wdata[SIDE_REG_W-1:0]);
               CSR_IGNORE_COLOR:    ignore_key = csr_wdata[COLOR_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            blit_results_q.push_back(blit_step(func_type'(req_ch.func), req_ch.pixel,
                                               req_ch.word_address, req_ch.last));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (blit_results_q.size() == 0) begin
               $error("response transaction with no request outstanding");
               error_count++;
            end else begin
               want = blit_results_q.pop_front();
               if (rsp_ch.read_data !== want.read_data) begin
                  $error("read_data: expected %h, actual %h", want.read_data,
                         rsp_ch.read_data);
                  error_count++;
               end
               if (rsp_ch.done_res !== want.done_res) begin
                  $error("done_res: expected %b, actual %b", want.done_res,
                         rsp_ch.done_res);
                  error_count++;
               end
               if (rsp_ch.collided !== want.collided) begin
                  $error("collided: expected %b, actual %b", want.collided,
                         rsp_ch.collided);
                  error_count++;
               end
            end
         end
      end
      pending = blit_results_q.size();
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import sbc_pkg::*;

   localparam int STALL_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     error_count;
   int                     pending;

   int                     idle_cycles;
   int                     sent_count;
   bit                     quiet;
   bit                     req_gaps;
   bit                     rsp_gaps;
   bit                     hold_request;

   int                     cur_w;
   int                     cur_h;
   int                     cur_cols;
   int                     cur_rows;
   logic [COLOR_W-1:0]     cur_ign;

   sbc_req_if req_ch ();
   sbc_rsp_if rsp_ch ();

   sprite_blit_with_collision u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sbc_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .pending     (pending)
   );

   initial clock = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (quiet) begin
            rsp_ch.ready = 1'b1;
            @(negedge clock);
         end else if (hold_request) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else if (rsp_gaps && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
      end
   end

   task automatic send_item(input func_type f, input logic [PIXEL_W-1:0] pix,
                            input logic [WORD_ADDR_W-1:0] adr, input logic lst);
      if (!quiet && req_gaps && $urandom_range(0, 5) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.func = f;
      req_ch.pixel = pix;
      req_ch.word_address = adr;
      req_ch.last = lst;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      if (f != FUNC_NONE) sent_count++;
   endtask

   task automatic drain();
      req_ch.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic apply_cfg(input int left, input int base, input int w, input int h,
                            input int cols, input int rows, input logic [COLOR_W-1:0] ign);
      drain();
      write_reg(CSR_SPRITE_LEFT, CSR_DATA_W'(left & 'h3FF));
      write_reg(CSR_SPRITE_BASE_ROW, CSR_DATA_W'(base & 'h3FF));
      write_reg(CSR_SPRITE_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_SPRITE_HEIGHT, CSR_DATA_W'(h));
      write_reg(CSR_SCREEN_COLUMNS, CSR_DATA_W'(cols));
      write_reg(CSR_SCREEN_ROWS, CSR_DATA_W'(rows));
      write_reg(CSR_IGNORE_COLOR, ign);
      cur_w = (w < 1) ? 1 : ((w > MAX_SIDE_DEF) ? MAX_SIDE_DEF : w);
      cur_h = (h < 1) ? 1 : ((h > MAX_SIDE_DEF) ? MAX_SIDE_DEF : h);
      cur_cols = cols;
      cur_rows = rows;
      cur_ign = ign;
   endtask

   function automatic logic [PIXEL_W-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0, 1:    return '0;
         2:       return {8'($urandom), cur_ign};
         3:       return {8'($urandom), 24'hA59999};
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [WORD_ADDR_W-1:0] pick_addr();
      int span;
      span = cur_cols * cur_rows;
      if (span > FB_DEPTH_DEF) span = FB_DEPTH_DEF;
      if (span == 0 || $urandom_range(0, 5) == 0) return WORD_ADDR_W'($urandom);
      return WORD_ADDR_W'($urandom_range(0, span - 1));
   endfunction

   task automatic send_direct();
      case ($urandom_range(0, 9))
         0:          send_item(FUNC_NONE, $urandom, WORD_ADDR_W'($urandom), 1'($urandom));
         1, 2, 3, 4: send_item(FUNC_WRITE, pick_pixel(), pick_addr(), 1'($urandom));
         default:    send_item(FUNC_READ, $urandom, pick_addr(), 1'($urandom));
      endcase
   endtask

   task automatic send_sprite();
      int total;
      int count;
      int pick;
      total = cur_w * cur_h;
      pick = $urandom_range(0, 9);
      if (total > 64) begin
         count = $urandom_range(1, 40);
      end else if (pick < 7) begin
         count = total;
      end else if (pick < 8) begin
         count = total + $urandom_range(1, 5);
      end else begin
         count = $urandom_range(1, total);
      end
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 19) == 0) send_direct();
         send_item(FUNC_PIXEL, pick_pixel(), WORD_ADDR_W'($urandom),
                   (i == count - 1) || ($urandom_range(0, 49) == 0));
      end
   endtask

   initial begin
      int phase;
      int cols;
      int rows;
      int w;
      int h;
      logic [COLOR_W-1:0] ign;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_PIXEL;
      req_ch.pixel = '0;
      req_ch.word_address = '0;
      req_ch.last = 1'b0;
      hold_request = 1'b0;
      quiet = 1'b0;
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      sent_count = 0;
      idle_cycles = 0;
      cur_w = 1;
      cur_h = 1;
      cur_cols = 256;
      cur_rows = 256;
      cur_ign = 24'hA59999;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      send_item(FUNC_READ, '0, 16'h0000, 1'b0);
      send_item(FUNC_READ, '0, 16'hFFFF, 1'b0);
      send_item(FUNC_WRITE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      send_item(FUNC_READ, '0, 16'hFFFF, 1'b1);
      send_item(FUNC_WRITE, 32'h00A5_9999, 16'd256, 1'b0);
      send_item(FUNC_PIXEL, 32'h1234_5678, 16'hFFFF, 1'b1);
      send_item(FUNC_PIXEL, 32'hFFFF_FFFF, 16'h0000, 1'b1);
      send_item(FUNC_PIXEL, 32'h0000_0000, 16'h0000, 1'b1);
      send_item(FUNC_NONE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      send_item(FUNC_READ, '0, 16'd256, 1'b0);
      send_item(FUNC_WRITE, 32'h8000_0000, 16'h0000, 1'b0);
      send_item(FUNC_READ, '0, 16'h0000, 1'b0);
      apply_cfg(-1, 0, 2, 1, 256, 256, 24'h000000);
      send_item(FUNC_PIXEL, 32'h0000_000A, 16'h0000, 1'b0);
      send_item(FUNC_PIXEL, 32'h0000_000B, 16'h0000, 1'b0);
      send_item(FUNC_PIXEL, 32'h0000_000C, 16'h0000, 1'b1);

      phase = 0;
      while (sent_count < 1100) begin
         case (phase)
            0: apply_cfg(-512, -512, 0, 0, 0, 0, 24'h000000);
            1: apply_cfg(511, 511, 511, 511, 511, 511, 24'hFFFFFF);
            2: apply_cfg(0, -1, 256, 256, 256, 256, 24'h000000);
            3: apply_cfg(-3, -2, 5, 4, 1, 1, 24'hA59999);
            4: apply_cfg(-2, 300, 3, 3, 511, 300, 24'h123456);
            default: begin
               cols = $urandom_range(4, 24);
               rows = $urandom_range(4, 24);
               w = $urandom_range(1, 6);
               h = $urandom_range(1, 6);
               if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 511);
               if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 511);
               case ($urandom_range(0, 3))
                  0:       ign = '0;
                  1:       ign = 24'hA59999;
                  default: ign = COLOR_W'($urandom);
               endcase
               apply_cfg(int'($urandom_range(0, cols + 8)) - 6,
                         int'($urandom_range(0, rows + 6)) - 6, w, h, cols, rows, ign);
            end
         endcase
         req_gaps = ($urandom_range(0, 3) != 0);
         rsp_gaps = ($urandom_range(0, 3) != 0);
         if (sent_count >= 950) quiet = 1'b1;
         if (phase == 8) begin
            hold_request = 1'b1;
            req_gaps = 1'b0;
            repeat (40) send_item(FUNC_PIXEL, pick_pixel(), WORD_ADDR_W'($urandom), 1'b0);
            send_item(FUNC_PIXEL, pick_pixel(), WORD_ADDR_W'($urandom), 1'b1);
            drain();
         end
         repeat ($urandom_range(2, 4)) begin
            send_sprite();
            repeat ($urandom_range(0, 4)) send_direct();
         end
         phase++;
      end

      req_ch.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (12) @(negedge clock);
      if (error_count == 0 && pending == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/sbc_pkg.sv
rtl/core/sbc_channels.sv
rtl/core/sbc_front.sv
rtl/core/sbc_queue.sv
rtl/core/sbc_back.sv
rtl/core/sprite_blit_with_collision.sv
verif/sbc_checker.sv
verif/testbench.sv
